// ===== hw/rtl/lpst_pkg.sv =====
// Shared types and constants for the length-prefixed SPI transfer core.
`timescale 1ns / 1ps
package lpst_pkg;

  localparam int unsigned CmdW        = 3;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned IdxW        = 9;
  localparam int unsigned RxCntW      = 9;
  localparam int unsigned BeatW       = 10;
  localparam int unsigned MinBeats    = 2;
  localparam int unsigned LenOverhead = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_QUEUE    = 3'd0,
    CMD_CLEAR_TX = 3'd1,
    CMD_START    = 3'd2,
    CMD_EXCHANGE = 3'd3,
    CMD_READ     = 3'd4,
    CMD_CLEAR_RX = 3'd5
  } lpst_cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] rx_byte;
    logic [IdxW-1:0]  read_index;
  } lpst_req_t;

  typedef struct packed {
    logic [ByteW-1:0]  tx_byte;
    logic              tx_valid;
    logic              transfer_done;
    logic              queue_error;
    logic [ByteW-1:0]  rx_data;
    logic [RxCntW-1:0] rx_count;
    logic [BeatW-1:0]  beat_total;
  } lpst_rsp_t;

  // Result status computed in the execute stage; store read data joins it once the status is registered.
  typedef struct packed {
    logic              tx_valid;
    logic              done;
    logic              qerr;
    logic              use_tx;
    logic              use_rx;
    logic [RxCntW-1:0] rx_count;
    logic [BeatW-1:0]  beat_total;
  } lpst_meta_t;

endpackage

// ===== hw/rtl/lpst_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface lpst_req_if;
  import lpst_pkg::*;
  logic      valid;
  logic      ready;
  lpst_req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface lpst_rsp_if;
  import lpst_pkg::*;
  logic      valid;
  logic      ready;
  lpst_rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

// ===== hw/rtl/lpst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lpst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lpst_ctrl.sv =====
// Execute stage: transfer state registers, command decode and store port control.
`timescale 1ns / 1ps
module lpst_ctrl import lpst_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            exec_i,
  input  lpst_req_t                       req_i,
  output lpst_meta_t                      meta_o,
  output logic                            tx_we_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] tx_waddr_o,
  output logic                            tx_re_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] tx_raddr_o,
  output logic                            rx_we_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rx_waddr_o,
  output logic                            rx_re_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rx_raddr_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  logic [CW-1:0]     tx_fill_q, tx_fill_d;
  logic [CW-1:0]     tx_pos_q, tx_pos_d;
  logic [RxCntW-1:0] rx_pos_q, rx_pos_d;
  logic [RxCntW-1:0] rx_exp_q, rx_exp_d;
  logic [CW-1:0]     beat_lim_q, beat_lim_d;
  logic [CW-1:0]     beats_q, beats_d;
  logic [31:0]       beat_ext;

  always_comb begin
    tx_fill_d  = tx_fill_q;
    tx_pos_d   = tx_pos_q;
    rx_pos_d   = rx_pos_q;
    rx_exp_d   = rx_exp_q;
    beat_lim_d = beat_lim_q;
    beats_d    = beats_q;
    meta_o     = '0;
    tx_we_o    = 1'b0;
    tx_re_o    = 1'b0;
    rx_we_o    = 1'b0;
    rx_re_o    = 1'b0;
    tx_waddr_o = tx_fill_q[AW-1:0];
    tx_raddr_o = tx_pos_q[AW-1:0];
    rx_waddr_o = AW'(rx_pos_q);
    rx_raddr_o = AW'(req_i.read_index);

    case (req_i.command)
      CMD_QUEUE: begin
        if (tx_fill_q < CW'(BUFFER_DEPTH)) begin
          tx_we_o   = exec_i;
          tx_fill_d = tx_fill_q + CW'(1);
        end else begin
          meta_o.qerr = 1'b1;
        end
      end
      CMD_CLEAR_TX: begin
        tx_fill_d = '0;
      end
      CMD_START: begin
        tx_pos_d   = '0;
        rx_pos_d   = '0;
        beats_d    = '0;
        rx_exp_d   = RxCntW'(MinBeats);
        beat_lim_d = (tx_fill_q > CW'(MinBeats)) ? tx_fill_q : CW'(MinBeats);
      end
      CMD_EXCHANGE: begin
        if (beats_q < beat_lim_q) begin
          meta_o.tx_valid = 1'b1;
          if (tx_pos_q < tx_fill_q) begin
            meta_o.use_tx = 1'b1;
            tx_re_o       = exec_i;
            tx_pos_d      = tx_pos_q + CW'(1);
          end
          // rx_expected never exceeds 257, so it also bounds the store address
          if (rx_pos_q < rx_exp_q) begin
            rx_we_o  = exec_i;
            rx_pos_d = rx_pos_q + RxCntW'(1);
            if (rx_pos_q == RxCntW'(1)) begin
              // second byte is the reply length
              rx_exp_d = RxCntW'(req_i.rx_byte) + RxCntW'(LenOverhead);
              if (CW'(rx_exp_d) > beat_lim_q) begin
                beat_lim_d = CW'(rx_exp_d);
              end
            end
          end
          beats_d     = beats_q + CW'(1);
          meta_o.done = (beats_d >= beat_lim_d);
        end else begin
          meta_o.done = 1'b1;
        end
      end
      CMD_READ: begin
        if (32'(req_i.read_index) < BUFFER_DEPTH) begin
          meta_o.use_rx = 1'b1;
          rx_re_o       = exec_i;
        end
      end
      CMD_CLEAR_RX: begin
        rx_exp_d = '0;
      end
      default: begin
      end
    endcase

    beat_ext          = 32'(beat_lim_d);
    meta_o.rx_count   = rx_exp_d;
    meta_o.beat_total = beat_ext[BeatW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_fill_q  <= '0;
      tx_pos_q   <= '0;
      rx_pos_q   <= '0;
      rx_exp_q   <= '0;
      beat_lim_q <= '0;
      beats_q    <= '0;
    end else if (exec_i) begin
      tx_fill_q  <= tx_fill_d;
      tx_pos_q   <= tx_pos_d;
      rx_pos_q   <= rx_pos_d;
      rx_exp_q   <= rx_exp_d;
      beat_lim_q <= beat_lim_d;
      beats_q    <= beats_d;
    end
  end

endmodule

// ===== hw/rtl/length_prefixed_spi_transfer_core.sv =====
// Top level of the length-prefixed SPI master transfer core.
`timescale 1ns / 1ps
// Sequences one full-duplex SPI master transaction whose reply length arrives
// in its second received byte. Each request (queue, clear, start, exchange
// beat, read, clear rx) yields exactly one result. Requests are taken one per
// cycle unless the result channel stalls: a request sits in an input register,
// executes against the transfer state and the two byte stores once the output
// register is free or being drained, and its result is then presented from
// the output register; further requests are accepted while earlier ones are
// in flight. The transmit and receive stores are single-port-write RAMs of
// BUFFER_DEPTH bytes with registered reads; reading a receive entry that was
// never written returns undefined data.
module length_prefixed_spi_transfer_core import lpst_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpst_req_if.sink    req_i,
  lpst_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic       s1_valid_q;
  lpst_req_t  s1_req_q;
  logic       s2_valid_q;
  lpst_meta_t s2_meta_q;
  lpst_meta_t meta_d;
  logic       exec;

  logic          tx_we, tx_re, rx_we, rx_re;
  logic [AW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
  logic [ByteW-1:0] tx_rdata, rx_rdata;

  // execute when the result register is free or being drained this cycle
  assign exec        = s1_valid_q && (!s2_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (exec) begin
        s2_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_req_q <= req_i.req;
    end
    if (exec) begin
      s2_meta_q <= meta_d;
    end
  end

  lpst_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exec_i    (exec),
    .req_i     (s1_req_q),
    .meta_o    (meta_d),
    .tx_we_o   (tx_we),
    .tx_waddr_o(tx_waddr),
    .tx_re_o   (tx_re),
    .tx_raddr_o(tx_raddr),
    .rx_we_o   (rx_we),
    .rx_waddr_o(rx_waddr),
    .rx_re_o   (rx_re),
    .rx_raddr_o(rx_raddr)
  );

  lpst_ram #(
    .WIDTH(ByteW),
    .DEPTH(BUFFER_DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(tx_waddr),
    .wdata_i(s1_req_q.data_byte),
    .re_i   (tx_re),
    .raddr_i(tx_raddr),
    .rdata_o(tx_rdata)
  );

  lpst_ram #(
    .WIDTH(ByteW),
    .DEPTH(BUFFER_DEPTH)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .waddr_i(rx_waddr),
    .wdata_i(s1_req_q.rx_byte),
    .re_i   (rx_re),
    .raddr_i(rx_raddr),
    .rdata_o(rx_rdata)
  );

  // read data holds while stalled since no new read is issued
  assign rsp_o.valid             = s2_valid_q;
  assign rsp_o.rsp.tx_byte       = s2_meta_q.use_tx ? tx_rdata : '0;
  assign rsp_o.rsp.tx_valid      = s2_meta_q.tx_valid;
  assign rsp_o.rsp.transfer_done = s2_meta_q.done;
  assign rsp_o.rsp.queue_error   = s2_meta_q.qerr;
  assign rsp_o.rsp.rx_data       = s2_meta_q.use_rx ? rx_rdata : '0;
  assign rsp_o.rsp.rx_count      = s2_meta_q.rx_count;
  assign rsp_o.rsp.beat_total    = s2_meta_q.beat_total;

endmodule

// ===== tb/sv/length_prefixed_spi_transfer_core_tb.sv =====
// Testbench for length_prefixed_spi_transfer_core: directed and random requests, checked against a local model.
`timescale 1ns / 1ps
module length_prefixed_spi_transfer_core_tb;
  import lpst_pkg::*;

  localparam int unsigned BufDepth    = 512;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned NumPhases   = 4;
  localparam int unsigned DrainCycles = 8;
  // Command codes the core does not decode; they only report status.
  localparam logic [CmdW-1:0] CmdRsvdA = 3'd6;
  localparam logic [CmdW-1:0] CmdRsvdB = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  lpst_req_if req_if ();
  lpst_rsp_if rsp_if ();

  length_prefixed_spi_transfer_core #(
    .BUFFER_DEPTH(BufDepth)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Expected behavior of the core.
  logic [ByteW-1:0] tx_mem [BufDepth];
  logic [ByteW-1:0] rx_mem [BufDepth];
  int unsigned q_fill   = 0;
  int unsigned q_pos    = 0;
  int unsigned rx_pos   = 0;
  int unsigned rx_len   = 0;
  int unsigned beat_lim = 0;
  int unsigned beat_cnt = 0;

  lpst_req_t   pending_reqs [$];
  lpst_rsp_t   expected_rsps [$];
  int unsigned reqs_in_flight = 0;
  int unsigned stim_count     = 0;
  int unsigned rsp_count      = 0;
  int unsigned err_count      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned send_pct [NumPhases] = '{0, 85, 0, 30};
  int unsigned recv_pct [NumPhases] = '{0, 0, 85, 30};
  // Receive entries 0 .. rx_prefix-1 are known to have been written.
  int unsigned rx_prefix = 0;
  logic        req_taken = 1'b0;

  function automatic lpst_rsp_t transfer_step(input lpst_req_t r);
    lpst_rsp_t o;
    o = '0;
    case (r.command)
      CMD_QUEUE: begin
        if (q_fill < BufDepth) begin
          tx_mem[q_fill] = r.data_byte;
          q_fill++;
        end else begin
          o.queue_error = 1'b1;
        end
      end
      CMD_CLEAR_TX: q_fill = 0;
      CMD_START: begin
        q_pos    = 0;
        rx_pos   = 0;
        beat_cnt = 0;
        rx_len   = MinBeats;
        beat_lim = (q_fill > MinBeats) ? q_fill : MinBeats;
      end
      CMD_EXCHANGE: begin
        if (beat_cnt < beat_lim) begin
          o.tx_valid = 1'b1;
          if (q_pos < q_fill && q_pos < BufDepth) begin
            o.tx_byte = tx_mem[q_pos];
            q_pos++;
          end
          if (rx_pos < rx_len && rx_pos < BufDepth) begin
            rx_mem[rx_pos] = r.rx_byte;
            rx_pos++;
            // second byte of the reply carries its length
            if (rx_pos == MinBeats) begin
              rx_len = r.rx_byte + LenOverhead;
              if (rx_len > beat_lim) beat_lim = rx_len;
            end
          end
          beat_cnt++;
          o.transfer_done = (beat_cnt >= beat_lim);
        end else begin
          o.transfer_done = 1'b1;
        end
      end
      CMD_READ: begin
        if (r.read_index < BufDepth) o.rx_data = rx_mem[r.read_index];
      end
      CMD_CLEAR_RX: rx_len = 0;
      default: ;
    endcase
    o.rx_count   = rx_len[RxCntW-1:0];
    o.beat_total = beat_lim[BeatW-1:0];
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH result %0d: %s", rsp_count, msg);
    err_count++;
  endtask

  task automatic check_field(input string fname, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", fname, got, want));
  endtask

  // Request driver: changes inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (!req_if.valid || req_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_if.req   <= pending_reqs.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: samples both channels on the rising edge.
  always @(posedge clk) begin : monitor
    lpst_rsp_t want;
    lpst_rsp_t got;
    req_taken <= rst_n && req_if.valid && req_if.ready;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.rsp;
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_rsps.pop_front();
          check_field("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
          check_field("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
          check_field("transfer_done", 32'(got.transfer_done), 32'(want.transfer_done));
          check_field("queue_error", 32'(got.queue_error), 32'(want.queue_error));
          check_field("rx_data", 32'(got.rx_data), 32'(want.rx_data));
          check_field("rx_count", 32'(got.rx_count), 32'(want.rx_count));
          check_field("beat_total", 32'(got.beat_total), 32'(want.beat_total));
          reqs_in_flight--;
        end
        rsp_count++;
      end
      if (req_if.valid && req_if.ready) expected_rsps.push_back(transfer_step(req_if.req));
    end
  end

  task automatic push_req(input lpst_req_t r);
    pending_reqs.push_back(r);
    reqs_in_flight++;
    if (r.command <= CMD_CLEAR_RX) stim_count++;
  endtask

  function automatic lpst_req_t rand_fields(input logic [CmdW-1:0] cmd);
    lpst_req_t r;
    r.command    = cmd;
    r.data_byte  = ByteW'($urandom_range(0, 255));
    r.rx_byte    = ByteW'($urandom_range(0, 255));
    r.read_index = IdxW'($urandom_range(0, 511));
    return r;
  endfunction

  task automatic push_fields(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] data,
                             input logic [ByteW-1:0] rxb, input logic [IdxW-1:0] idx);
    lpst_req_t r;
    r.command    = cmd;
    r.data_byte  = data;
    r.rx_byte    = rxb;
    r.read_index = idx;
    push_req(r);
  endtask

  task automatic push_read();
    lpst_req_t r;
    r = rand_fields(CMD_READ);
    r.read_index = IdxW'($urandom_range(0, rx_prefix - 1));
    push_req(r);
  endtask

  // One well-formed transaction: load nq bytes, start, run nb beats with the
  // length byte len; clr is the beat before which rx is cleared (> nb: never).
  task automatic run_transfer(input int unsigned nq, input int unsigned len,
                              input int unsigned nb, input int unsigned clr);
    lpst_req_t   r;
    int unsigned wr;
    push_req(rand_fields(CMD_CLEAR_TX));
    for (int unsigned i = 0; i < nq; i++) push_req(rand_fields(CMD_QUEUE));
    push_req(rand_fields(CMD_START));
    for (int unsigned b = 0; b < nb; b++) begin
      if (b == clr) push_req(rand_fields(CMD_CLEAR_RX));
      r = rand_fields(CMD_EXCHANGE);
      if (b == 1) r.rx_byte = ByteW'(len);
      push_req(r);
    end
    if (clr == nb) push_req(rand_fields(CMD_CLEAR_RX));
    wr = nb;
    if (clr < wr) wr = clr;
    if (len + LenOverhead < wr) wr = len + LenOverhead;
    if (wr > rx_prefix) rx_prefix = wr;
    if (rx_prefix > 0) repeat ($urandom_range(0, 3)) push_read();
  endtask

  task automatic random_transfer();
    int unsigned nq;
    int unsigned len;
    int unsigned total;
    int unsigned nb;
    int unsigned clr;
    nq    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
    len   = ($urandom_range(0, 99) < 94) ? $urandom_range(0, 8) : $urandom_range(0, 255);
    total = (nq > len + LenOverhead) ? nq : len + LenOverhead;
    // land a couple of beats short of, on, or past the end
    nb    = total + $urandom_range(0, 4) - 2;
    clr   = ($urandom_range(0, 99) < 15) ? $urandom_range(0, nb) : nb + 1;
    run_transfer(nq, len, nb, clr);
  endtask

  task automatic random_noise(input int unsigned n);
    logic [CmdW-1:0] cmd;
    repeat (n) begin
      cmd = CmdW'($urandom_range(0, 7));
      if (cmd == CMD_READ && rx_prefix == 0) cmd = CMD_EXCHANGE;
      if (cmd == CMD_READ) push_read();
      else push_req(rand_fields(cmd));
    end
  endtask

  task automatic wait_idle();
    while (reqs_in_flight != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    req_if.valid = 1'b0;
    req_if.req   = '0;
    rsp_if.ready = 1'b0;
    rst_n        = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // exchange before any start, unknown commands, empty clears
    push_fields(CMD_EXCHANGE, 8'hFF, 8'hFF, 9'h1FF);
    push_fields(CmdRsvdA, 8'hFF, 8'hFF, 9'h1FF);
    push_fields(CmdRsvdB, 8'h00, 8'h00, 9'h000);
    push_fields(CMD_CLEAR_RX, 8'h00, 8'h00, 9'h000);
    push_fields(CMD_CLEAR_TX, 8'hFF, 8'hFF, 9'h1FF);
    // start with nothing queued: two beats of padding, length byte zero
    push_fields(CMD_START, 8'h00, 8'h00, 9'h000);
    push_fields(CMD_EXCHANGE, 8'h00, 8'hFF, 9'h000);
    push_fields(CMD_EXCHANGE, 8'hFF, 8'h00, 9'h1FF);
    push_fields(CMD_EXCHANGE, 8'h00, 8'h5A, 9'h000);
    // three bytes queued, reply announces four more, rx cleared mid-reply
    push_fields(CMD_QUEUE, 8'h00, 8'hFF, 9'h1FF);
    push_fields(CMD_QUEUE, 8'hFF, 8'h00, 9'h000);
    push_fields(CMD_QUEUE, 8'hA5, 8'h5A, 9'h0AA);
    push_fields(CMD_START, 8'h00, 8'h00, 9'h000);
    push_fields(CMD_EXCHANGE, 8'h00, 8'h3C, 9'h000);
    push_fields(CMD_EXCHANGE, 8'h00, 8'h04, 9'h000);
    push_fields(CMD_EXCHANGE, 8'h00, 8'hC3, 9'h000);
    push_fields(CMD_CLEAR_RX, 8'h00, 8'h00, 9'h000);
    push_fields(CMD_EXCHANGE, 8'h00, 8'h77, 9'h000);
    push_fields(CMD_EXCHANGE, 8'h00, 8'h88, 9'h000);
    push_fields(CMD_EXCHANGE, 8'h00, 8'h99, 9'h000);
    push_fields(CMD_EXCHANGE, 8'h00, 8'h11, 9'h000);
    rx_prefix = 3;
    push_fields(CMD_READ, 8'hFF, 8'hFF, 9'h000);
    push_fields(CMD_READ, 8'h00, 8'h00, 9'h002);
    wait_idle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      phase_start    = stim_count;
      if (p == 0) begin
        // full store plus overflow, longest reply, every beat of the maximum transfer
        run_transfer(BufDepth + 3, 255, BufDepth + 1, BufDepth + 2);
        push_fields(CMD_READ, 8'h00, 8'hFF, 9'd256);
        push_fields(CMD_READ, 8'hFF, 8'h00, 9'd255);
      end
      while (stim_count - phase_start < PhaseItems) begin
        if ($urandom_range(0, 99) < 75) random_transfer();
        else random_noise($urandom_range(1, 6));
      end
      // sender holds off until every result is back
      wait_idle();
    end

    repeat (DrainCycles) @(negedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
